/* rtl/core/mrse_pkg.sv */
// Shared types and constants of the Modbus RTU slave frame engine.
// Holds event codes, function codes and the CRC-16 byte step.
// No dependencies.
package mrse_pkg;

   typedef enum logic [2:0] {
      EV_WAIT    = 3'd0,
      EV_SERVED  = 3'd1,
      EV_ADDR    = 3'd2,
      EV_CRC     = 3'd3,
      EV_ILL_FN  = 3'd4,
      EV_ILL_VAL = 3'd5,
      EV_OVF     = 3'd6
   } event_type;

   localparam logic [7:0] FC_READ_HOLD  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT = 8'd4;
   localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
   localparam logic [7:0] FC_WRITE_MANY = 8'd16;
   localparam logic [7:0] FC_EXC_FLAG   = 8'h80;

   localparam logic [7:0] EXC_ILL_FN  = 8'd1;
   localparam logic [7:0] EXC_ILL_VAL = 8'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // one byte through the reflected CRC-16, a bit per step
   function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/core/mrse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the receive ring and the parameter table. No dependencies.
module mrse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/modbus_rtu_slave_frame_engine.sv */
// Modbus RTU slave frame engine: byte ring, frame scan, CRC check and replies.
// Depends on mrse_pkg and on mrse_ram (ring and parameter table).
//
//  channel | dir | handshake          | contents
//  req     | in  | tvalid/tready      | tdata: rx_byte; tuser: opcode
//  rsp     | out | tvalid/tready/tlast| tdata: event, pending, 8 bytes, count; tuser: has_reply
//  csr     | in  | wr_en              | wr_data: own station address
//
// The scan reads the frame through the CRC pass, one ring read per cycle, set by the single
// ring read port; a write-multiple then reads two ring bytes and writes a word per register,
// and a reply is emitted byte by byte, with a table read before each register of a read.
// After reset a clearing pass writes PARAM_COUNT zero words; no word is taken meanwhile.
// A full output register stalls reply assembly; no new word is taken while it waits.
module modbus_rtu_slave_frame_engine #(
   parameter int RING_DEPTH   = 512,
   parameter int PARAM_COUNT  = 256,
   parameter int MAX_QUANTITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [2:0] event_code, [3] scan_pending,
                                    // [67:4] reply_bytes, [71:68] reply_count
   output logic [0:0]  rsp_tuser,   // [0] has_reply
   output logic        rsp_tlast
);
   import mrse_pkg::*;

   localparam int RA  = $clog2(RING_DEPTH);
   localparam int FW  = $clog2(RING_DEPTH + 1);
   localparam int PAW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD0, ST_CHK0, ST_CHK1, ST_CHK6, ST_CRC, ST_CRCCHK,
      ST_WM_HI, ST_WM_LO, ST_WM_WR, ST_POP, ST_EMIT, ST_RDW, ST_FINAL
   } state_type;

   typedef enum logic [1:0] {RK_NONE, RK_EXC, RK_ECHO, RK_READ} kind_type;

   state_type         state_ff, state_in;
   logic [RA-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [7:0]        addr_ff, addr_in;
   logic [PAW-1:0]    clr_ff, clr_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        fc_ff, fc_in;
   logic [8:0]        flen_ff, flen_in, iss_ff, iss_in, didx_ff, didx_in, popn_ff, popn_in;
   logic              dv_ff, dv_in;
   logic [15:0]       crc_ff, crc_in, rcrc_ff, rcrc_in, a_ff, a_in, q_ff, q_in;
   event_type         ev_ff, ev_in;
   logic              pend_ff, pend_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        exc_ff, exc_in, ridx_ff, ridx_in;
   logic [6:0]        wi_ff, wi_in;
   logic [7:0]        whi_ff, whi_in;
   logic              hv_ff, hv_in, lv_ff, lv_in, pz_ff, pz_in;
   logic [63:0]       pack_ff, pack_in;
   logic [3:0]        pcnt_ff, pcnt_in;
   logic              ovalid_ff, ovalid_in, olast_ff, olast_in, ohas_ff, ohas_in;
   logic [2:0]        oev_ff, oev_in;
   logic              opend_ff, opend_in;

   logic              ring_we, ring_re;
   logic [8:0]        ring_off;
   logic [RA-1:0]     ring_raddr;
   logic [7:0]        ring_rdata;
   logic              par_we, par_re;
   logic [PAW-1:0]    par_waddr, par_raddr;
   logic [15:0]       par_wdata, par_rdata;

   function automatic logic [RA-1:0] ring_at(input logic [RA-1:0] base, input logic [8:0] off);
      logic [RA:0] s;
      s = (RA+1)'(base) + (RA+1)'(off);
      if (s >= (RA+1)'(RING_DEPTH)) begin
         s = s - (RA+1)'(RING_DEPTH);
      end
      return s[RA-1:0];
   endfunction

   function automatic logic id_ok(input logic [15:0] id);
      return {1'b0, id} < 17'(PARAM_COUNT);
   endfunction

   logic        accept, can_emit, emit_go, emit_last, emit_body;
   logic [7:0]  blen, emit_b, nxt;
   logic [15:0] wid;
   logic [8:0]  lim;
   logic [3:0]  base;
   logic [63:0] base_pack;
   logic [FW-1:0] fill_after;
   logic [2:0]  ev_out;

   assign accept   = req_tvalid && req_tready;
   assign can_emit = !ovalid_ff || rsp_tready;
   assign wid      = a_ff + 16'(wi_ff);
   assign lim      = flen_ff - 9'd2;
   assign ev_out   = ovf_ff ? EV_OVF : ev_ff;
   assign ring_raddr = ring_at(head_ff, ring_off);

   always_comb begin
      case (kind_ff)
         RK_EXC:  blen = 8'd3;
         RK_ECHO: blen = 8'd6;
         RK_READ: blen = 8'd3 + {q_ff[6:0], 1'b0};
         default: blen = 8'd0;
      endcase
      emit_body = ridx_ff < blen;
      emit_last = ridx_ff == blen + 8'd1;
      case (ridx_ff)
         8'd0:    emit_b = addr_ff;
         8'd1:    emit_b = (kind_ff == RK_EXC) ? (fc_ff | FC_EXC_FLAG) : fc_ff;
         8'd2:    emit_b = (kind_ff == RK_EXC) ? exc_ff :
                           (kind_ff == RK_ECHO) ? a_ff[15:8] : {q_ff[6:0], 1'b0};
         default: begin
            if (kind_ff == RK_ECHO) begin
               case (ridx_ff)
                  8'd3:    emit_b = a_ff[7:0];
                  8'd4:    emit_b = q_ff[15:8];
                  default: emit_b = q_ff[7:0];
               endcase
            end else begin
               // read data: high byte at odd positions
               emit_b = pz_ff ? 8'd0 : (ridx_ff[0] ? par_rdata[15:8] : par_rdata[7:0]);
            end
         end
      endcase
      if (!emit_body) begin
         emit_b = (ridx_ff == blen) ? crc_ff[7:0] : crc_ff[15:8];
      end
   end

   always_comb begin
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff; fill_in = fill_ff;
      addr_in = csr_wr_en ? csr_wr_data : addr_ff;
      clr_in = clr_ff; ovf_in = ovf_ff; fc_in = fc_ff; flen_in = flen_ff;
      iss_in = iss_ff; didx_in = didx_ff; popn_in = popn_ff; dv_in = 1'b0;
      crc_in = crc_ff; rcrc_in = rcrc_ff; a_in = a_ff; q_in = q_ff;
      ev_in = ev_ff; pend_in = pend_ff; kind_in = kind_ff; exc_in = exc_ff;
      ridx_in = ridx_ff; wi_in = wi_ff; whi_in = whi_ff;
      hv_in = hv_ff; lv_in = lv_ff; pz_in = pz_ff;
      pack_in = pack_ff; pcnt_in = pcnt_ff; ovalid_in = ovalid_ff;
      olast_in = olast_ff; ohas_in = ohas_ff; oev_in = oev_ff; opend_in = opend_ff;
      ring_we = 1'b0; ring_re = 1'b0; ring_off = 9'd0;
      par_we = 1'b0; par_re = 1'b0; par_waddr = clr_ff; par_raddr = wid[PAW-1:0];
      par_wdata = 16'd0;
      req_tready = state_ff == ST_IDLE;
      emit_go = 1'b0; nxt = ridx_ff + 8'd1;
      base = ovalid_ff ? 4'd0 : pcnt_ff;
      base_pack = ovalid_ff ? 64'd0 : pack_ff;
      fill_after = fill_ff - FW'(popn_ff);

      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0; pack_in = 64'd0; pcnt_in = 4'd0;
      end

      case (state_ff)
         ST_CLEAR: begin
            par_we = 1'b1;
            clr_in = clr_ff + PAW'(1);
            if (clr_ff == PAW'(PARAM_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               ovf_in = 1'b0;
               kind_in = RK_NONE;
               if (!req_tuser[0]) begin
                  ring_we = 1'b1;
                  tail_in = ring_at(tail_ff, 9'd1);
                  if (fill_ff == FW'(RING_DEPTH)) begin
                     head_in = ring_at(head_ff, 9'd1);
                     ovf_in = 1'b1;
                  end else begin
                     fill_in = fill_ff + FW'(1);
                  end
               end
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            if (fill_ff < FW'(4)) begin
               ev_in = EV_WAIT; pend_in = 1'b0; state_in = ST_FINAL;
            end else begin
               ring_re = 1'b1; ring_off = 9'd0; state_in = ST_CHK0;
            end
         end
         ST_CHK0: begin
            if (ring_rdata != addr_ff) begin
               ev_in = EV_ADDR; popn_in = 9'd1; state_in = ST_POP;
            end else begin
               ring_re = 1'b1; ring_off = 9'd1; state_in = ST_CHK1;
            end
         end
         ST_CHK1: begin
            fc_in = ring_rdata;
            crc_in = CRC_INIT; iss_in = 9'd0;
            if (ring_rdata == FC_READ_HOLD || ring_rdata == FC_READ_INPUT ||
                ring_rdata == FC_WRITE_ONE) begin
               flen_in = 9'd8;
               if (fill_ff < FW'(8)) begin
                  ev_in = EV_WAIT; pend_in = 1'b0; state_in = ST_FINAL;
               end else begin
                  state_in = ST_CRC;
               end
            end else if (ring_rdata == FC_WRITE_MANY) begin
               if (fill_ff < FW'(7)) begin
                  ev_in = EV_WAIT; pend_in = 1'b0; state_in = ST_FINAL;
               end else begin
                  ring_re = 1'b1; ring_off = 9'd6; state_in = ST_CHK6;
               end
            end else begin
               kind_in = RK_EXC; exc_in = EXC_ILL_FN; ev_in = EV_ILL_FN;
               popn_in = 9'd1; state_in = ST_POP;
            end
         end
         ST_CHK6: begin
            flen_in = 9'd9 + 9'(ring_rdata);
            if (fill_ff < FW'(9'd9 + 9'(ring_rdata))) begin
               ev_in = EV_WAIT; pend_in = 1'b0; state_in = ST_FINAL;
            end else begin
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            // ring reads are issued ahead of the CRC update; each byte is used when its registered read data returns
            if (iss_ff < flen_ff) begin
               ring_re = 1'b1; ring_off = iss_ff;
               iss_in = iss_ff + 9'd1; dv_in = 1'b1; didx_in = iss_ff;
            end
            if (dv_ff) begin
               if (didx_ff < lim) begin
                  crc_in = crc_step(crc_ff, ring_rdata);
               end
               case (didx_ff)
                  9'd2:    a_in[15:8] = ring_rdata;
                  9'd3:    a_in[7:0]  = ring_rdata;
                  9'd4:    q_in[15:8] = ring_rdata;
                  9'd5:    q_in[7:0]  = ring_rdata;
                  default: ;
               endcase
               if (didx_ff == lim) begin
                  rcrc_in[7:0] = ring_rdata;
               end
               if (didx_ff == flen_ff - 9'd1) begin
                  rcrc_in[15:8] = ring_rdata;
                  state_in = ST_CRCCHK;
               end
            end
         end
         ST_CRCCHK: begin
            wi_in = 7'd0;
            popn_in = flen_ff;
            if (crc_ff != rcrc_ff) begin
               ev_in = EV_CRC; popn_in = 9'd1; state_in = ST_POP;
            end else if (fc_ff == FC_WRITE_ONE) begin
               par_we = id_ok(a_ff); par_waddr = a_ff[PAW-1:0]; par_wdata = q_ff;
               kind_in = RK_ECHO; ev_in = EV_SERVED; state_in = ST_POP;
            end else if (q_ff > 16'(MAX_QUANTITY)) begin
               kind_in = RK_EXC; exc_in = EXC_ILL_VAL; ev_in = EV_ILL_VAL; state_in = ST_POP;
            end else if (fc_ff == FC_WRITE_MANY) begin
               state_in = ST_WM_HI;
            end else begin
               kind_in = RK_READ; ev_in = EV_SERVED; state_in = ST_POP;
            end
         end
         ST_WM_HI: begin
            if (wi_ff == q_ff[6:0]) begin
               kind_in = RK_ECHO; ev_in = EV_SERVED; state_in = ST_POP;
            end else begin
               ring_re = 1'b1; ring_off = 9'd7 + 9'({wi_ff, 1'b0});
               hv_in = FW'(ring_off) < fill_ff;
               state_in = ST_WM_LO;
            end
         end
         ST_WM_LO: begin
            whi_in = hv_ff ? ring_rdata : 8'd0;
            ring_re = 1'b1; ring_off = 9'd8 + 9'({wi_ff, 1'b0});
            lv_in = FW'(ring_off) < fill_ff;
            state_in = ST_WM_WR;
         end
         ST_WM_WR: begin
            par_we = id_ok(wid); par_waddr = wid[PAW-1:0];
            par_wdata = {whi_ff, lv_ff ? ring_rdata : 8'd0};
            wi_in = wi_ff + 7'd1;
            state_in = ST_WM_HI;
         end
         ST_POP: begin
            head_in = ring_at(head_ff, popn_ff);
            fill_in = fill_after;
            pend_in = (ev_ff != EV_WAIT) && (fill_after >= FW'(4));
            ridx_in = 8'd0; crc_in = CRC_INIT; wi_in = 7'd0;
            state_in = (kind_ff == RK_NONE) ? ST_FINAL : ST_EMIT;
         end
         ST_RDW: begin
            par_re = 1'b1; pz_in = !id_ok(wid); state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_emit) begin
               emit_go = 1'b1;
               ridx_in = nxt;
               if (emit_body) begin
                  crc_in = crc_step(crc_ff, emit_b);
               end
               if (kind_ff == RK_READ && ridx_ff >= 8'd4 && emit_body && !ridx_ff[0]) begin
                  wi_in = wi_ff + 7'd1;
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == RK_READ && nxt >= 8'd3 && nxt < blen && nxt[0]) begin
                  state_in = ST_RDW;
               end
            end
         end
         ST_FINAL: begin
            if (can_emit) begin
               pack_in = 64'd0; pcnt_in = 4'd0; ovalid_in = 1'b1; olast_in = 1'b1;
               ohas_in = 1'b0; oev_in = ev_out; opend_in = pend_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit_go) begin
         pack_in = base_pack | ({emit_b, 56'd0} >> {base[2:0], 3'b000});
         pcnt_in = base + 4'd1;
         oev_in = ev_out; opend_in = pend_ff;
         if (base == 4'd7 || emit_last) begin
            ovalid_in = 1'b1; olast_in = emit_last; ohas_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; head_ff <= '0; tail_ff <= '0; fill_ff <= '0;
         addr_ff <= 8'd1; clr_ff <= '0; ovalid_ff <= 1'b0; dv_ff <= 1'b0;
         kind_ff <= RK_NONE; ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in; fill_ff <= fill_in;
         addr_ff <= addr_in; clr_ff <= clr_in; ovalid_ff <= ovalid_in; dv_ff <= dv_in;
         kind_ff <= kind_in; ovf_ff <= ovf_in;
      end
      fc_ff <= fc_in; flen_ff <= flen_in; iss_ff <= iss_in; didx_ff <= didx_in;
      popn_ff <= popn_in; crc_ff <= crc_in; rcrc_ff <= rcrc_in; a_ff <= a_in; q_ff <= q_in;
      ev_ff <= ev_in; pend_ff <= pend_in; exc_ff <= exc_in; ridx_ff <= ridx_in;
      wi_ff <= wi_in; whi_ff <= whi_in; hv_ff <= hv_in; lv_ff <= lv_in; pz_ff <= pz_in;
      pack_ff <= pack_in; pcnt_ff <= pcnt_in; olast_ff <= olast_in; ohas_ff <= ohas_in;
      oev_ff <= oev_in; opend_ff <= opend_in;
   end

   mrse_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (tail_ff),
      .wr_data (req_tdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   mrse_ram #(.WIDTH(16), .DEPTH(PARAM_COUNT)) u_param (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_en   (par_re),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {pcnt_ff, pack_ff, opend_ff, oev_ff};
   assign rsp_tuser  = ohas_ff;
   assign rsp_tlast  = olast_ff;
endmodule
